[sv/gsfs_pkg.sv]
// ----------------------------------------------------------------------------
// gsfs_pkg
// shared types, codes and sizes of the gate slot frame selector
// ----------------------------------------------------------------------------
`default_nettype none
package gsfs_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int GATE_SLOTS  = 16;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_WR  = 2'd1;
	localparam logic [1:0] MODE_DEQ = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SENT = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic [15:0] flow;
		logic [7:0]  phase;
		logic [15:0] tag;
	} desc_t;

	typedef struct packed {
		logic [15:0] flow;
		logic [7:0]  phase;
	} slot_t;

	typedef struct packed {
		logic              shift;
		logic              load;
		logic [QIDX_W-1:0] load_idx;
		desc_t             load_d;
	} qctrl_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

endpackage
`default_nettype wire

[sv/gsfs_if.sv]
// ----------------------------------------------------------------------------
// gsfs request and response channels
// valid/ready handshake carrying one item
// ----------------------------------------------------------------------------
`default_nettype none
interface gsfs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] flow_id;
	logic [7:0]  phase;
	logic [15:0] frame_tag;
	logic [3:0]  slot_index;

	modport source (output valid, mode, flow_id, phase, frame_tag, slot_index, input ready);
	modport sink   (input valid, mode, flow_id, phase, frame_tag, slot_index, output ready);
endinterface

interface gsfs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] sent_flow_id;
	logic [7:0]  sent_phase;
	logic [15:0] sent_tag;
	logic [5:0]  late_dropped;
	logic [5:0]  queue_level;

	modport source (output valid, status, sent_flow_id, sent_phase, sent_tag, late_dropped,
		queue_level, input ready);
	modport sink   (input valid, status, sent_flow_id, sent_phase, sent_tag, late_dropped,
		queue_level, output ready);
endinterface
`default_nettype wire

[sv/gsfs_cell.sv]
// ----------------------------------------------------------------------------
// gsfs_cell
// one descriptor cell: shifts from its right neighbor or loads a new entry
// ----------------------------------------------------------------------------
`default_nettype none
module gsfs_cell (
	input  wire logic          clk,
	input  wire logic          shift,
	input  wire logic          load,
	input  wire gsfs_pkg::desc_t load_d,
	input  wire gsfs_pkg::desc_t right_d,
	output gsfs_pkg::desc_t    d_q
);
	import gsfs_pkg::*;

	always_ff @(posedge clk) begin
		if (load) begin
			d_q <= load_d;
		end else if (shift) begin
			d_q <= right_d;
		end
	end

endmodule
`default_nettype wire

[sv/gsfs_queue.sv]
// ----------------------------------------------------------------------------
// gsfs_queue
// row of descriptor cells, head at cell zero, shifting toward the head
// ----------------------------------------------------------------------------
`default_nettype none
module gsfs_queue (
	input  wire logic           clk,
	input  wire gsfs_pkg::qctrl_t ctrl,
	output gsfs_pkg::desc_t     head
);
	import gsfs_pkg::*;

	desc_t cell_d [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		desc_t right;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid
			assign right = cell_d[i+1];
		end
		gsfs_cell u_cell (
			.clk     (clk),
			.shift   (ctrl.shift),
			.load    (ctrl.load && (ctrl.load_idx == QIDX_W'(i))),
			.load_d  (ctrl.load_d),
			.right_d (right),
			.d_q     (cell_d[i])
		);
	end

	assign head = cell_d[0];

endmodule
`default_nettype wire

[sv/gate_slot_frame_selector_unit.sv]
// ----------------------------------------------------------------------------
// gate_slot_frame_selector_unit
// gate control list driven selection of queued frame descriptors
// ----------------------------------------------------------------------------
// usage
//   req carries one item: enqueue a descriptor, write a gate list slot, or
//   ask for a dequeue at the current gate slot. rsp returns one item per req
//   item, in order, from an output register.
//   enqueue and slot write answer in the cycle after acceptance.
//   a dequeue rotates the whole descriptor row once through its head cell,
//   one descriptor per cycle; an empty queue is answered without a scan.
//   a full queue holds 32. early entries and all entries after the match
//   go back to the tail, the sent one and late ones before the match are
//   dropped, so order is kept. the late check compares the head against
//   all gate slots at once. one item is in flight at a time; req.ready is
//   low during a dequeue scan and while a result waits in the output
//   register and is not taken. a stalled receiver holds rsp; nothing is lost.
//   reset empties the queue (level zero); gate slots hold garbage until
//   written and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module gate_slot_frame_selector_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	gsfs_req_if.sink  req,
	gsfs_rsp_if.source rsp
);
	import gsfs_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;     // descriptors held
	logic [CNT_W-1:0]  left_q;      // descriptors still to visit in the scan
	logic              matched_q;
	logic [5:0]        late_q;
	slot_t             cur_q;       // gate slot being served
	logic [GATE_SLOTS-1:0] late_mask_q; // slots before the current one
	slot_t             gate_q [GATE_SLOTS];
	desc_t             sent_q;

	logic              out_v_q;
	logic [1:0]        st_q;
	desc_t             o_sent_q;
	logic [5:0]        o_late_q;
	logic [5:0]        o_level_q;

	qctrl_t            qctrl;
	desc_t             head;
	logic              acc;
	logic              is_match, is_late, keep, scan_done;
	logic [GATE_SLOTS-1:0] hit;
	logic              slot_ok;

	gsfs_queue u_queue (
		.clk  (clk),
		.ctrl (qctrl),
		.head (head)
	);

	assign req.ready = (state_q == S_IDLE) && (!out_v_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign slot_ok   = 32'(req.slot_index) < GATE_SLOTS;

	// head against every gate slot in parallel
	always_comb begin
		for (int i = 0; i < GATE_SLOTS; i++) begin
			hit[i] = (gate_q[i].flow == head.flow) && (gate_q[i].phase == head.phase);
		end
	end

	assign is_match  = !matched_q && (head.flow == cur_q.flow) && (head.phase == cur_q.phase);
	assign is_late   = !matched_q && !is_match && |(hit & late_mask_q);
	assign keep      = !(is_match || is_late);
	assign scan_done = (state_q == S_SCAN) && (left_q == CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && req.mode == MODE_DEQ && slot_ok && count_q != '0) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// queue control
	always_comb begin
		qctrl = '0;
		case (state_q)
			S_IDLE: begin
				qctrl.load_idx = count_q[QIDX_W-1:0];
				qctrl.load_d   = '{flow: req.flow_id, phase: req.phase, tag: req.frame_tag};
				qctrl.load     = acc && req.mode == MODE_ENQ && count_q != CNT_W'(QUEUE_DEPTH);
			end
			S_SCAN: begin
				// pop head, kept entries return at the tail
				qctrl.shift    = 1'b1;
				qctrl.load     = keep;
				qctrl.load_idx = QIDX_W'(count_q - CNT_W'(1));
				qctrl.load_d   = head;
			end
			default: qctrl = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && req.mode == MODE_WR && slot_ok) begin
			gate_q[req.slot_index] <= '{flow: req.flow_id, phase: req.phase};
		end
		if (acc && req.mode == MODE_DEQ) begin
			cur_q <= gate_q[req.slot_index];
			for (int i = 0; i < GATE_SLOTS; i++) begin
				late_mask_q[i] <= 32'(i) < 32'(req.slot_index);
			end
		end
		if (state_q == S_SCAN && is_match) begin
			sent_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			left_q    <= '0;
			matched_q <= 1'b0;
			late_q    <= '0;
			out_v_q   <= 1'b0;
			st_q      <= ST_OK;
			o_sent_q  <= '0;
			o_late_q  <= '0;
			o_level_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (acc) begin
				case (req.mode)
					MODE_ENQ: begin
						out_v_q  <= 1'b1;
						o_sent_q <= '0;
						o_late_q <= '0;
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							st_q      <= ST_FULL;
							o_level_q <= 6'(count_q);
						end else begin
							st_q      <= ST_OK;
							count_q   <= count_q + CNT_W'(1);
							o_level_q <= 6'(count_q + CNT_W'(1));
						end
					end
					MODE_WR: begin
						out_v_q   <= 1'b1;
						st_q      <= ST_OK;
						o_sent_q  <= '0;
						o_late_q  <= '0;
						o_level_q <= 6'(count_q);
					end
					MODE_DEQ: begin
						left_q    <= count_q;
						matched_q <= 1'b0;
						late_q    <= '0;
						if (!slot_ok || count_q == '0) begin
							out_v_q   <= 1'b1;
							st_q      <= ST_NONE;
							o_sent_q  <= '0;
							o_late_q  <= '0;
							o_level_q <= 6'(count_q);
						end
					end
					default: begin
						out_v_q   <= 1'b1;
						st_q      <= ST_NONE;
						o_sent_q  <= '0;
						o_late_q  <= '0;
						o_level_q <= 6'(count_q);
					end
				endcase
			end
			if (state_q == S_SCAN) begin
				left_q <= left_q - CNT_W'(1);
				if (!keep) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (is_match) begin
					matched_q <= 1'b1;
				end
				if (is_late) begin
					late_q <= late_q + 6'd1;
				end
				if (scan_done) begin
					out_v_q   <= 1'b1;
					st_q      <= (matched_q || is_match) ? ST_SENT : ST_NONE;
					o_sent_q  <= is_match ? head : (matched_q ? sent_q : '0);
					o_late_q  <= is_late ? late_q + 6'd1 : late_q;
					o_level_q <= keep ? 6'(count_q) : 6'(count_q - CNT_W'(1));
				end
			end
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = st_q;
	assign rsp.sent_flow_id = o_sent_q.flow;
	assign rsp.sent_phase   = o_sent_q.phase;
	assign rsp.sent_tag     = o_sent_q.tag;
	assign rsp.late_dropped = o_late_q;
	assign rsp.queue_level  = o_level_q;

	// queue never overfills
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

	// no new item during a scan
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !req.ready)
		else $error("item taken during scan");

	// scan visits only held descriptors
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (left_q != '0) && (left_q <= count_q))
		else $error("scan counter out of range");

	// no second match and no late drop after a match
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && matched_q |-> !is_match && !is_late)
		else $error("second removal after match");

endmodule
`default_nettype wire
